### rtl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by the active-low reset.
`define FQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, gated by the active-low reset.
`define FQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

### rtl/fq2d_pkg.sv
// Package for the Q16.16 to decimal text formatter: item type, states,
// character codes and the divide-by-ten helper. No dependencies.
package fq2d_pkg;

    localparam int INT_DIGITS  = 5;
    localparam int FRAC_DIGITS = 6;
    localparam int STEP_W      = 3;
    localparam int IPART_W     = 16;
    localparam int FPART_W     = 20;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [19:0] FRAC_SCALE = 20'd1000000;
    // ceil(2^23 / 10): exact quotient for every 20-bit dividend
    localparam logic [19:0] DIV10_MAGIC = 20'd838861;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // One classified number waiting for conversion
    typedef struct packed {
        logic               neg;
        logic [IPART_W-1:0] ipart;
        logic [FPART_W-1:0] fpart;
    } fq2d_item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CONV,
        BK_SIGN,
        BK_INT,
        BK_DOT,
        BK_FRAC
    } fq2d_back_state_t;

    // floor(x / 10) by reciprocal multiplication
    function automatic logic [FPART_W-1:0] div10(input logic [FPART_W-1:0] x);
        logic [2*FPART_W-1:0] prod;
        prod = {{FPART_W{1'b0}}, x} * {{FPART_W{1'b0}}, DIV10_MAGIC};
        return FPART_W'(prod[2*FPART_W-1:23]);
    endfunction

    // x - 10 * q, known to be a single digit
    function automatic logic [3:0] rem10(input logic [FPART_W-1:0] x,
                                         input logic [FPART_W-1:0] q);
        logic [FPART_W-1:0] diff;
        diff = x - ((q << 3) + (q << 1));
        return diff[3:0];
    endfunction

endpackage

### rtl/fq2d_front.sv
// Front end: takes one Q16.16 word, splits sign, integer part and scaled
// fraction, and hands the result to the queue. Depends on fq2d_pkg.
module fq2d_front (
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  fixed_value,
    output logic                push_valid,
    input  logic                push_ready,
    output fq2d_pkg::fq2d_item_t push_item
);

    logic        neg;
    logic [31:0] mag;
    logic [35:0] frac_prod;

    // Magnitude; the most negative word maps to 0x80000000 (integer 32768)
    assign neg = fixed_value[31];
    assign mag = neg ? (~fixed_value + 32'd1) : fixed_value;

    // Six fraction digits as an integer: floor(low16 * 10^6 / 2^16)
    assign frac_prod = {4'b0, mag[15:0], 16'b0} >> 16 == 36'b0
                       ? 36'b0 : {20'b0, mag[15:0]} * {16'b0, fq2d_pkg::FRAC_SCALE};

    assign push_item.neg   = neg;
    assign push_item.ipart = mag[31:16];
    assign push_item.fpart = frac_prod[35:16];

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

### rtl/fq2d_queue.sv
// Short FIFO between front and back end, one item per slot.
// Depends on fq2d_pkg for the item type.
module fq2d_queue #(
    parameter int DEPTH = fq2d_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  fq2d_pkg::fq2d_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output fq2d_pkg::fq2d_item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fq2d_pkg::fq2d_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/fq2d_back.sv
// Back end: converts integer and fraction to decimal digits one per cycle
// with separate divide-by-ten units, then emits the characters. Uses fq2d_pkg.
module fq2d_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  fq2d_pkg::fq2d_item_t pop_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           text_char,
    output logic                 last_char
);

    localparam int IW = fq2d_pkg::IPART_W;
    localparam int FW = fq2d_pkg::FPART_W;
    localparam int SW = fq2d_pkg::STEP_W;

    fq2d_pkg::fq2d_back_state_t state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic [SW-1:0] nint_reg, nint_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic          neg_reg, neg_next;
    logic [IW-1:0] iwork_reg, iwork_next;
    logic [FW-1:0] fwork_reg, fwork_next;
    logic [3:0]    idig_reg [fq2d_pkg::INT_DIGITS];
    logic [3:0]    idig_next [fq2d_pkg::INT_DIGITS];
    logic [3:0]    fdig_reg [fq2d_pkg::FRAC_DIGITS];
    logic [3:0]    fdig_next [fq2d_pkg::FRAC_DIGITS];
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    char_reg, char_next;
    logic          last_reg, last_next;

    logic [FW-1:0] iquo, fquo;
    logic [3:0]    irem, frem;
    logic          out_free;

    // Divide-by-ten units for both digit strings
    assign iquo = fq2d_pkg::div10({{(FW-IW){1'b0}}, iwork_reg});
    assign irem = fq2d_pkg::rem10({{(FW-IW){1'b0}}, iwork_reg}, iquo);
    assign fquo = fq2d_pkg::div10(fwork_reg);
    assign frem = fq2d_pkg::rem10(fwork_reg, fquo);

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign text_char = char_reg;
    assign last_char = last_reg;

    // State and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fq2d_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        nint_reg  <= nint_next;
        idx_reg   <= idx_next;
        neg_reg   <= neg_next;
        iwork_reg <= iwork_next;
        fwork_reg <= fwork_next;
        idig_reg  <= idig_next;
        fdig_reg  <= fdig_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    // Sequencer: fetch, convert, then one character per free output slot
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        nint_next      = nint_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        iwork_next     = iwork_reg;
        fwork_next     = fwork_reg;
        idig_next      = idig_reg;
        fdig_next      = fdig_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        pop_ready      = 1'b0;

        unique case (state_reg)
            fq2d_pkg::BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    neg_next   = pop_item.neg;
                    iwork_next = pop_item.ipart;
                    fwork_next = pop_item.fpart;
                    step_next  = '0;
                    nint_next  = SW'(1);
                    state_next = fq2d_pkg::BK_CONV;
                end
            end
            fq2d_pkg::BK_CONV:
            begin
                // fraction digits fill from the right
                fdig_next[SW'(fq2d_pkg::FRAC_DIGITS - 1) - step_reg] = frem;
                fwork_next = fquo;
                if (step_reg < SW'(fq2d_pkg::INT_DIGITS))
                begin
                    idig_next[step_reg] = irem;
                    iwork_next          = iquo[IW-1:0];
                    // a nonzero remaining value makes this digit significant
                    if (iwork_reg != '0)
                    begin
                        nint_next = step_reg + 1'b1;
                    end
                end
                if (step_reg == SW'(fq2d_pkg::FRAC_DIGITS - 1))
                begin
                    idx_next   = nint_reg - 1'b1;
                    state_next = neg_reg ? fq2d_pkg::BK_SIGN : fq2d_pkg::BK_INT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            fq2d_pkg::BK_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = fq2d_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = fq2d_pkg::BK_INT;
                end
            end
            fq2d_pkg::BK_INT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = fq2d_pkg::CHAR_ZERO + {4'b0, idig_reg[idx_reg]};
                    last_next      = 1'b0;
                    if (idx_reg == '0)
                    begin
                        state_next = fq2d_pkg::BK_DOT;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            fq2d_pkg::BK_DOT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = fq2d_pkg::CHAR_DOT;
                    last_next      = 1'b0;
                    idx_next       = '0;
                    state_next     = fq2d_pkg::BK_FRAC;
                end
            end
            fq2d_pkg::BK_FRAC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = fq2d_pkg::CHAR_ZERO + {4'b0, fdig_reg[idx_reg]};
                    if (idx_reg == SW'(fq2d_pkg::FRAC_DIGITS - 1))
                    begin
                        last_next  = 1'b1;
                        state_next = fq2d_pkg::BK_IDLE;
                    end
                    else
                    begin
                        last_next = 1'b0;
                        idx_next  = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = fq2d_pkg::BK_IDLE;
            end
        endcase
    end

endmodule

### rtl/fixed_q16_to_decimal_text.sv
// Formats a signed Q16.16 word as decimal ASCII text, one character per
// output transfer: optional '-', integer digits without leading zeros, '.',
// six truncated fraction digits, the last character flagged by last_char.
// The front end classifies a word in the cycle it is taken and parks it in a
// small queue, so input transfers continue while the previous number is
// still printing. Per number the back end fetches it from the queue, converts
// both parts in its divide-by-ten units (one digit of each part per cycle),
// then emits its 8 to 13 characters as the output accepts them.
module fixed_q16_to_decimal_text #(
    parameter int QUEUE_DEPTH = fq2d_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] fixed_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         text_char,
    output logic               last_char
);

    logic                 push_valid, push_ready;
    logic                 pop_valid, pop_ready;
    fq2d_pkg::fq2d_item_t push_item, pop_item;

    fq2d_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .fixed_value (fixed_value),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    fq2d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    fq2d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .text_char (text_char),
        .last_char (last_char)
    );

endmodule

### rtl/fq2d_checker.sv
// Port-level checks on the text output of the formatter, bound to the top.
// Depends on fq2d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fq2d_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] text_char,
    input logic       last_char
);

    // A stalled character holds
    `FQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(text_char) && $stable(last_char))

    // Only sign, point or digit characters appear
    `FQ_ASSERT_IMPL(a_char_set, clk, rst_n, out_valid, (text_char == fq2d_pkg::CHAR_MINUS) || (text_char == fq2d_pkg::CHAR_DOT) || ((text_char >= fq2d_pkg::CHAR_ZERO) && (text_char <= fq2d_pkg::CHAR_NINE)))

    // Text always ends on a fraction digit
    `FQ_ASSERT_IMPL(a_last_digit, clk, rst_n, out_valid && last_char, (text_char >= fq2d_pkg::CHAR_ZERO) && (text_char <= fq2d_pkg::CHAR_NINE))

    // Sign and point are never the final character
    `FQ_ASSERT_IMPL(a_mark_not_last, clk, rst_n, out_valid && ((text_char == fq2d_pkg::CHAR_MINUS) || (text_char == fq2d_pkg::CHAR_DOT)), !last_char)

endmodule

bind fixed_q16_to_decimal_text fq2d_checker u_fq2d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .text_char (text_char),
    .last_char (last_char)
);

### tb/sv/fq2d_text_board_pkg.sv
// Scoreboard for the Q16.16 to decimal text formatter: predicts the character
// stream of every accepted word and checks output transfers in order.
// Depends on fq2d_pkg for the character codes and digit counts.
package fq2d_text_board_pkg;

    import fq2d_pkg::*;

    // One expected output transfer
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    class text_scoreboard;

        text_char_t pending_chars[$];

        function void push_char(input logic [7:0] code);
            text_char_t entry;
            entry.code = code;
            entry.last = 1'b0;
            pending_chars.push_back(entry);
        endfunction

        // Predict the text of one accepted word and queue its characters
        function void note_number(input logic [31:0] word);
            logic              neg;
            logic [31:0]       mag;
            int unsigned       ipart;
            longint unsigned   frac;
            logic [7:0]        int_digits[$];
            logic [7:0]        frac_digits[FRAC_DIGITS];
            neg   = word[31];
            // most negative word keeps magnitude 2^31, integer part 32768
            mag   = neg ? (~word + 32'd1) : word;
            ipart = mag[31:16];
            // truncated, never rounded
            frac  = (64'(mag[15:0]) * 64'(FRAC_SCALE)) >> 16;

            if (neg)
                push_char(CHAR_MINUS);

            // integer digits, no leading zeros, lone zero when empty
            do
            begin
                int_digits.push_front(8'(CHAR_ZERO + ipart % 10));
                ipart = ipart / 10;
            end while (ipart != 0);
            foreach (int_digits[k])
                push_char(int_digits[k]);

            push_char(CHAR_DOT);

            // fraction digits, zero padded to full width
            for (int k = FRAC_DIGITS - 1; k >= 0; k--)
            begin
                frac_digits[k] = 8'(CHAR_ZERO + frac % 10);
                frac = frac / 10;
            end
            foreach (frac_digits[k])
                push_char(frac_digits[k]);

            pending_chars[pending_chars.size() - 1].last = 1'b1;
        endfunction

        // Compare one output transfer with the oldest expectation;
        // returns an empty string on a match
        function string check_char(input logic [7:0] code, input logic last);
            text_char_t want;
            string      msg;
            msg = "";
            if (pending_chars.size() == 0)
                return $sformatf("char 0x%02h last=%0b with nothing pending", code, last);
            want = pending_chars.pop_front();
            if (code !== want.code)
                msg = $sformatf("text_char got 0x%02h want 0x%02h", code, want.code);
            if (last !== want.last)
                msg = {msg, (msg.len() != 0) ? ", " : "",
                       $sformatf("last_char got %0b want %0b", last, want.last)};
            return msg;
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

    endclass

endpackage

### tb/sv/fixed_q16_to_decimal_text_test.sv
// Top-level testbench for fixed_q16_to_decimal_text: directed edge words,
// then random words under several idle and stall mixes and back pressure.
// Depends on fq2d_pkg and fq2d_text_board_pkg.
module fixed_q16_to_decimal_text_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fq2d_pkg::*;
    import fq2d_text_board_pkg::*;

    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 120;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [31:0] fixed_value = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [7:0]  text_char;
    logic        last_char;

    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    int             hold_req       = 0;
    int             mismatch_count = 0;
    text_scoreboard board;

    fixed_q16_to_decimal_text DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .fixed_value(fixed_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .text_char  (text_char),
        .last_char  (last_char)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Offer one word, holding it until the input transfer happens
    task automatic send_value(input logic [31:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        fixed_value <= word;
        do @(posedge clk); while (!in_ready);
        board.note_number(word);
    endtask

    // Stop offering and wait until every predicted character has come out
    task automatic wait_for_text();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    // Random word, weighted toward digit-count edges and special fractions
    function automatic logic [31:0] random_word();
        logic [15:0] ip;
        logic [15:0] fp;
        logic [31:0] word;
        int unsigned decade_edges[9] = '{9, 10, 99, 100, 999, 1000, 9999, 10000, 32767};
        case ($urandom_range(9))
            0, 1, 2, 3:
                return $urandom();
            4, 5:
            begin
                ip = 16'($urandom_range(20));
                fp = 16'($urandom());
            end
            6, 7:
            begin
                ip = 16'(decade_edges[$urandom_range(8)]);
                fp = 16'($urandom());
            end
            default:
            begin
                ip = 16'($urandom());
                case ($urandom_range(4))
                    0: fp = 16'h0000;
                    1: fp = 16'h0001;
                    2: fp = 16'hFFFF;
                    3: fp = 16'h8000;
                    default: fp = 16'($urandom_range(70));
                endcase
            end
        endcase
        word = {ip, fp};
        if ($urandom_range(1) != 0)
            word = ~word + 32'd1;
        return word;
    endfunction

    // Output side: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every output transfer
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && out_valid && out_ready)
        begin
            msg = board.check_char(text_char, last_char);
            if (msg.len() != 0)
                report_mismatch(msg);
        end
    end

    // Main sequence
    initial
    begin
        logic [31:0] edge_words[$];
        int          idle_mix[4];
        int          stall_mix[4];
        edge_words = '{
            32'h0000_0000, 32'h0000_0001, 32'h0000_FFFF, 32'h0001_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF,
            32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000, 32'h0009_FFFF,
            32'h000A_0000, 32'h0063_FFFF, 32'h0064_0000, 32'h03E7_0000,
            32'h03E8_0000, 32'h270F_0000, 32'h2710_0000, 32'h7FFF_0000,
            32'h0000_0042, 32'h0000_000A, 32'h1234_5678, 32'hEDCB_A988,
            32'h5555_AAAA
        };
        idle_mix  = '{0, 69, 0, 22};
        stall_mix = '{0, 0, 69, 22};
        board = new();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words, no idling
        foreach (edge_words[k])
            send_value(edge_words[k]);
        wait_for_text();

        // Long output hold-off while words keep coming: input must stall
        hold_req <= hold_req + 1;
        repeat (30)
            send_value(random_word());
        wait_for_text();

        // Random words under each idle and stall mix
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_mix[p];
            recv_stall_pct = stall_mix[p];
            repeat (PHASE_ITEMS)
                send_value(random_word());
            wait_for_text();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
